FILE: rtl/tcf_pkg.sv
// tcf_pkg: shared types and constants of the tree centroid finder.
// Used by tcf_ctrl, tcf_datapath and tree_centroid_finder_core.
package tcf_pkg;

  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned NodeW    = 11;
  localparam int unsigned PartW    = 10;

  typedef struct packed {
    logic             func;
    logic [NodeW-1:0] end_a;
    logic [NodeW-1:0] end_b;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] centroid_node;
    logic [PartW-1:0] largest_part;
  } out_item_t;

  // datapath commands, one per controller step
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START, OP_CLR,
    OP_B0, OP_B1, OP_B2, OP_B3, OP_PUSH,
    OP_W0, OP_W1, OP_W2, OP_W3, OP_W4, OP_W5,
    OP_A0, OP_A1, OP_A2, OP_A3,
    OP_S0, OP_S1, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic edge_end;   // all stored edges scanned
    logic usable;     // current edge lies inside the tree
    logic hv;         // adjacency list of looked-up node not empty
    logic sp_zero;    // walk stack empty
    logic k_last;     // current slot is the tail of the list
    logic acc_end;    // size accumulation finished
    logic last_node;  // node counter at node count
  } dp_status_t;

endpackage

FILE: rtl/tcf_ctrl.sv
// tcf_ctrl: sequencer of the tree centroid finder.
// Depends on tcf_pkg; drives tcf_datapath through dp_cmd_t / dp_status_t.
module tcf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 func_i,
  input  tcf_pkg::dp_status_t  status_i,
  output tcf_pkg::dp_cmd_t     cmd_o,
  output logic                 busy
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_B0   = 5'd2;
  localparam logic [4:0] S_B1   = 5'd3;
  localparam logic [4:0] S_B2   = 5'd4;
  localparam logic [4:0] S_B3   = 5'd5;
  localparam logic [4:0] S_PUSH = 5'd6;
  localparam logic [4:0] S_W0   = 5'd7;
  localparam logic [4:0] S_W1   = 5'd8;
  localparam logic [4:0] S_W2   = 5'd9;
  localparam logic [4:0] S_W3   = 5'd10;
  localparam logic [4:0] S_W4   = 5'd11;
  localparam logic [4:0] S_W5   = 5'd12;
  localparam logic [4:0] S_A0   = 5'd13;
  localparam logic [4:0] S_A1   = 5'd14;
  localparam logic [4:0] S_A2   = 5'd15;
  localparam logic [4:0] S_A3   = 5'd16;
  localparam logic [4:0] S_S0   = 5'd17;
  localparam logic [4:0] S_S1   = 5'd18;
  localparam logic [4:0] S_EMIT = 5'd19;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = tcf_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (func_i) begin
            cmd_o.op = tcf_pkg::OP_START;
            state_d  = S_CLR;
          end else begin
            cmd_o.op = tcf_pkg::OP_LOAD;
          end
        end
      end
      S_CLR: begin
        cmd_o.op = tcf_pkg::OP_CLR;
        if (status_i.last_node) state_d = S_B0;
      end
      S_B0: begin
        cmd_o.op = tcf_pkg::OP_B0;
        state_d  = status_i.edge_end ? S_PUSH : S_B1;
      end
      S_B1: begin
        cmd_o.op = tcf_pkg::OP_B1;
        state_d  = status_i.usable ? S_B2 : S_B0;
      end
      S_B2: begin
        cmd_o.op = tcf_pkg::OP_B2;
        state_d  = S_B3;
      end
      S_B3: begin
        cmd_o.op = tcf_pkg::OP_B3;
        state_d  = S_B0;
      end
      S_PUSH: begin
        cmd_o.op = tcf_pkg::OP_PUSH;
        state_d  = S_W0;
      end
      S_W0: begin
        cmd_o.op = tcf_pkg::OP_W0;
        state_d  = status_i.sp_zero ? S_A0 : S_W1;
      end
      S_W1: begin
        cmd_o.op = tcf_pkg::OP_W1;
        state_d  = S_W2;
      end
      S_W2: begin
        cmd_o.op = tcf_pkg::OP_W2;
        state_d  = status_i.hv ? S_W3 : S_W0;
      end
      S_W3: begin
        cmd_o.op = tcf_pkg::OP_W3;
        state_d  = S_W4;
      end
      S_W4: begin
        cmd_o.op = tcf_pkg::OP_W4;
        state_d  = S_W5;
      end
      S_W5: begin
        cmd_o.op = tcf_pkg::OP_W5;
        state_d  = status_i.k_last ? S_W0 : S_W3;
      end
      S_A0: begin
        cmd_o.op = tcf_pkg::OP_A0;
        state_d  = status_i.acc_end ? S_S0 : S_A1;
      end
      S_A1: begin
        cmd_o.op = tcf_pkg::OP_A1;
        state_d  = S_A2;
      end
      S_A2: begin
        cmd_o.op = tcf_pkg::OP_A2;
        state_d  = S_A3;
      end
      S_A3: begin
        cmd_o.op = tcf_pkg::OP_A3;
        state_d  = S_A0;
      end
      S_S0: begin
        cmd_o.op = tcf_pkg::OP_S0;
        state_d  = S_S1;
      end
      S_S1: begin
        cmd_o.op = tcf_pkg::OP_S1;
        state_d  = status_i.last_node ? S_EMIT : S_S0;
      end
      S_EMIT: begin
        cmd_o.op = tcf_pkg::OP_EMIT;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

FILE: rtl/tcf_datapath.sv
// tcf_datapath: edge store, linked adjacency, walk stack and size stores.
// Depends on tcf_pkg; executes the commands of tcf_ctrl.
module tcf_datapath #(
  parameter int unsigned MAX_NODES = tcf_pkg::MaxNodes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tcf_pkg::dp_cmd_t                cmd_i,
  input  tcf_pkg::in_item_t               in_i,
  input  logic                            cfg_we_i,
  input  logic [tcf_pkg::NodeW-1:0]       cfg_wdata_i,
  output tcf_pkg::dp_status_t             status_o,
  output logic                            res_valid_o,
  output tcf_pkg::out_item_t              res_o
);

  localparam int unsigned NW = $clog2(MAX_NODES + 1);  // node number
  localparam int unsigned EW = $clog2(MAX_NODES);      // edge / stack index
  localparam int unsigned SW = EW + 1;                 // adjacency slot
  localparam int unsigned ND = MAX_NODES + 1;
  localparam int unsigned ED = MAX_NODES - 1;
  localparam int unsigned AD = 2 * (MAX_NODES - 1);

  tcf_pkg::op_e op;
  assign op = cmd_i.op;

  // ---------------- registers
  logic [tcf_pkg::NodeW-1:0] ncfg_q;
  logic [EW-1:0] cnt_q, ei_q;
  logic [NW-1:0] n_q, vi_q, sp_q, reached_q, ai_q;
  logic [NW-1:0] a_q, b_q, v_q, u_q, p_q, s_q, best_q, bn_q;
  logic [SW-1:0] k_q, tl_q, kn_q;

  // ---------------- memory read data
  logic [NW-1:0] ea_rd, eb_rd, up_rd, sub_rd, mx_rd, ord_rd, stk_rd, nbr_rd;
  logic [SW-1:0] head_rd, tail_rd, nxt_rd;
  logic          hv_rd, seen_rd;

  logic load_ok, usable;
  logic [NW-1:0] n_clamp, part, sum, mxnew;

  assign load_ok = (in_i.end_a != '0) && (in_i.end_b != '0)
                && (32'(in_i.end_a) <= MAX_NODES) && (32'(in_i.end_b) <= MAX_NODES)
                && (32'(cnt_q) < MAX_NODES - 1);
  assign usable  = (ea_rd != '0) && (eb_rd != '0) && (ea_rd <= n_q) && (eb_rd <= n_q)
                && (ea_rd != eb_rd);

  always_comb begin
    if (ncfg_q == '0) begin
      n_clamp = NW'(1);
    end else if (32'(ncfg_q) > MAX_NODES) begin
      n_clamp = NW'(MAX_NODES);
    end else begin
      n_clamp = NW'(ncfg_q);
    end
  end

  assign sum   = sub_rd + s_q;
  assign mxnew = (s_q > mx_rd) ? s_q : mx_rd;

  always_comb begin
    if (!seen_rd) begin
      part = n_q - NW'(1);
    end else if ((reached_q - sub_rd) > mx_rd) begin
      part = reached_q - sub_rd;
    end else begin
      part = mx_rd;
    end
  end

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncfg_q      <= tcf_pkg::NodeW'(1);
      cnt_q       <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= (op == tcf_pkg::OP_EMIT);
      if (cfg_we_i) ncfg_q <= cfg_wdata_i;
      if (op == tcf_pkg::OP_LOAD && load_ok) cnt_q <= cnt_q + EW'(1);
      if (op == tcf_pkg::OP_EMIT) cnt_q <= '0;
    end
  end

  // ---------------- working registers
  always_ff @(posedge clk_i) begin
    case (op)
      tcf_pkg::OP_START: begin
        n_q  <= n_clamp;
        vi_q <= NW'(1);
        ei_q <= '0;
      end
      tcf_pkg::OP_CLR:  vi_q <= vi_q + NW'(1);
      tcf_pkg::OP_B1: begin
        a_q <= ea_rd;
        b_q <= eb_rd;
        if (!usable) ei_q <= ei_q + EW'(1);
      end
      tcf_pkg::OP_B3:   ei_q <= ei_q + EW'(1);
      tcf_pkg::OP_PUSH: begin
        sp_q      <= NW'(1);
        reached_q <= '0;
      end
      tcf_pkg::OP_W0: begin
        if (sp_q != '0) sp_q <= sp_q - NW'(1);
        else            ai_q <= reached_q - NW'(1);
      end
      tcf_pkg::OP_W1: begin
        v_q       <= stk_rd;
        reached_q <= reached_q + NW'(1);
      end
      tcf_pkg::OP_W2: begin
        k_q  <= head_rd;
        tl_q <= tail_rd;
      end
      tcf_pkg::OP_W4: begin
        u_q  <= nbr_rd;
        kn_q <= nxt_rd;
      end
      tcf_pkg::OP_W5: begin
        if (!seen_rd) sp_q <= sp_q + NW'(1);
        k_q <= kn_q;
      end
      tcf_pkg::OP_A0: if (ai_q == '0) vi_q <= NW'(1);
      tcf_pkg::OP_A2: begin
        p_q <= up_rd;
        s_q <= sub_rd;
      end
      tcf_pkg::OP_A3:   ai_q <= ai_q - NW'(1);
      tcf_pkg::OP_S1: begin
        if (vi_q == NW'(1) || part < best_q) begin
          best_q <= part;
          bn_q   <= vi_q;
        end
        vi_q <= vi_q + NW'(1);
      end
      default: ;
    endcase
  end

  // ---------------- edge store
  logic [NW-1:0] ea_mem [ED];
  logic [NW-1:0] eb_mem [ED];
  always_ff @(posedge clk_i) begin
    if (op == tcf_pkg::OP_LOAD && load_ok) begin
      ea_mem[cnt_q] <= NW'(in_i.end_a);
      eb_mem[cnt_q] <= NW'(in_i.end_b);
    end
    ea_rd <= ea_mem[ei_q];
    eb_rd <= eb_mem[ei_q];
  end

  // ---------------- adjacency lists (head, tail, valid per node; next, neighbor per slot)
  logic          hv_we, hv_wd;
  logic [NW-1:0] hv_wa, nd_ra;
  logic          head_we, tail_we, nxt_we, nbr_we;
  logic [NW-1:0] at_wa;
  logic [SW-1:0] slot, nbr_wa_s;
  logic [NW-1:0] other;

  assign slot = (op == tcf_pkg::OP_B3) ? {ei_q, 1'b1} : {ei_q, 1'b0};
  assign at_wa = (op == tcf_pkg::OP_B3) ? b_q : a_q;
  assign other = (op == tcf_pkg::OP_B3) ? a_q : b_q;
  assign nbr_wa_s = slot;

  always_comb begin
    hv_we   = 1'b0;
    hv_wd   = 1'b0;
    hv_wa   = at_wa;
    head_we = 1'b0;
    tail_we = 1'b0;
    nxt_we  = 1'b0;
    nbr_we  = 1'b0;
    case (op)
      tcf_pkg::OP_CLR: begin
        hv_we = 1'b1;
        hv_wa = vi_q;
      end
      tcf_pkg::OP_B2, tcf_pkg::OP_B3: begin
        hv_we   = 1'b1;
        hv_wd   = 1'b1;
        tail_we = 1'b1;
        nbr_we  = 1'b1;
        head_we = !hv_rd;
        nxt_we  = hv_rd;
      end
      default: ;
    endcase
    case (op)
      tcf_pkg::OP_B1: nd_ra = ea_rd;
      tcf_pkg::OP_B2: nd_ra = b_q;
      default:        nd_ra = stk_rd;
    endcase
  end

  logic          hv_mem   [ND];
  logic [SW-1:0] head_mem [ND];
  logic [SW-1:0] tail_mem [ND];
  logic [SW-1:0] nxt_mem  [AD];
  logic [NW-1:0] nbr_mem  [AD];

  always_ff @(posedge clk_i) begin
    if (hv_we) hv_mem[hv_wa] <= hv_wd;
    hv_rd <= hv_mem[nd_ra];
  end
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[at_wa] <= slot;
    head_rd <= head_mem[nd_ra];
  end
  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[at_wa] <= slot;
    tail_rd <= tail_mem[nd_ra];
  end
  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[tail_rd] <= slot;
    nxt_rd <= nxt_mem[k_q];
  end
  always_ff @(posedge clk_i) begin
    if (nbr_we) nbr_mem[nbr_wa_s] <= other;
    nbr_rd <= nbr_mem[k_q];
  end

  // ---------------- walk: seen, parent, stack, visit order
  logic          seen_we, seen_wd;
  logic [NW-1:0] seen_wa, seen_ra;
  logic          stk_we;
  logic [EW-1:0] stk_wa, stk_ra;
  logic [NW-1:0] stk_wd;

  always_comb begin
    seen_we = 1'b0;
    seen_wd = 1'b1;
    seen_wa = u_q;
    stk_we  = 1'b0;
    stk_wa  = sp_q[EW-1:0];
    stk_wd  = u_q;
    case (op)
      tcf_pkg::OP_CLR: begin
        seen_we = 1'b1;
        seen_wd = 1'b0;
        seen_wa = vi_q;
      end
      tcf_pkg::OP_PUSH: begin
        seen_we = 1'b1;
        seen_wa = NW'(1);
        stk_we  = 1'b1;
        stk_wa  = '0;
        stk_wd  = NW'(1);
      end
      tcf_pkg::OP_W5: begin
        seen_we = !seen_rd;
        stk_we  = !seen_rd;
      end
      default: ;
    endcase
    seen_ra = (op == tcf_pkg::OP_W4) ? nbr_rd : vi_q;
    stk_ra  = EW'(sp_q - NW'(1));
  end

  logic          seen_mem [ND];
  logic [NW-1:0] up_mem   [ND];
  logic [NW-1:0] stk_mem  [MAX_NODES];
  logic [NW-1:0] ord_mem  [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    seen_rd <= seen_mem[seen_ra];
  end
  always_ff @(posedge clk_i) begin
    if (op == tcf_pkg::OP_W5 && !seen_rd) up_mem[u_q] <= v_q;
    up_rd <= up_mem[ord_rd];
  end
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end
  always_ff @(posedge clk_i) begin
    if (op == tcf_pkg::OP_W1) ord_mem[reached_q[EW-1:0]] <= stk_rd;
    ord_rd <= ord_mem[ai_q[EW-1:0]];
  end

  // ---------------- subtree size and largest child size
  logic          sub_we, mx_we;
  logic [NW-1:0] sub_wa, sub_wd, sub_ra, mx_wa, mx_wd, mx_ra;

  always_comb begin
    sub_we = 1'b0;
    sub_wa = p_q;
    sub_wd = sum;
    mx_we  = 1'b0;
    mx_wa  = p_q;
    mx_wd  = mxnew;
    case (op)
      tcf_pkg::OP_W1: begin
        sub_we = 1'b1;
        sub_wa = stk_rd;
        sub_wd = NW'(1);
      end
      tcf_pkg::OP_A3: begin
        sub_we = 1'b1;
        mx_we  = 1'b1;
      end
      tcf_pkg::OP_CLR: begin
        mx_we = 1'b1;
        mx_wa = vi_q;
        mx_wd = '0;
      end
      default: ;
    endcase
    case (op)
      tcf_pkg::OP_A1: sub_ra = ord_rd;
      tcf_pkg::OP_A2: sub_ra = up_rd;
      default:        sub_ra = vi_q;
    endcase
    mx_ra = (op == tcf_pkg::OP_A2) ? up_rd : vi_q;
  end

  logic [NW-1:0] sub_mem [ND];
  logic [NW-1:0] mx_mem  [ND];

  always_ff @(posedge clk_i) begin
    if (sub_we) sub_mem[sub_wa] <= sub_wd;
    sub_rd <= sub_mem[sub_ra];
  end
  always_ff @(posedge clk_i) begin
    if (mx_we) mx_mem[mx_wa] <= mx_wd;
    mx_rd <= mx_mem[mx_ra];
  end

  // ---------------- status and result
  assign status_o.edge_end  = (ei_q == cnt_q);
  assign status_o.usable    = usable;
  assign status_o.hv        = hv_rd;
  assign status_o.sp_zero   = (sp_q == '0);
  assign status_o.k_last    = (k_q == tl_q);
  assign status_o.acc_end   = (ai_q == '0);
  assign status_o.last_node = (vi_q == n_q);

  assign res_o.centroid_node = tcf_pkg::NodeW'(bn_q);
  assign res_o.largest_part  = tcf_pkg::PartW'(best_q);

endmodule

FILE: rtl/tree_centroid_finder_core.sv
// Tree centroid finder. Edge items leave busy low and can be sent back to back.
// Compute item: busy rises and stays high until the result is out. The result
// strobe lasts one cycle, in the cycle busy drops; the receiver cannot stall.
// Reset: async active low; node count 1, edge store empty, idle.
module tree_centroid_finder_core #(
  parameter int unsigned MAX_NODES = tcf_pkg::MaxNodes
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tcf_pkg::in_item_t          in_i,
  input  logic                       cfg_we_i,
  input  logic [tcf_pkg::NodeW-1:0]  cfg_wdata_i,
  output logic                       res_valid_o,
  output tcf_pkg::out_item_t         res_o
);

  // Compute sequence: clear per-node flags, link edges into per-node lists
  // in edge order, stack walk from node 1, accumulate subtree sizes in
  // reverse visit order, then scan nodes for the smallest largest part.
  tcf_pkg::dp_cmd_t    cmd;
  tcf_pkg::dp_status_t status;

  tcf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (in_i.func),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  tcf_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // a compute item must make the block busy
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.func) |=> busy) else $error("compute not started");

  // an edge item never leaves the block busy
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !in_i.func) |=> !busy) else $error("edge load stalled");

  // one strobe per compute
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result repeated");

  // strobe follows the end of a compute
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!busy && $past(busy))) else $error("stray result");

  // centroid node is never zero
  a_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.centroid_node != '0)) else $error("bad centroid node");

endmodule

FILE: tb/tb_tree_centroid_finder_core.sv
// Testbench for tree_centroid_finder_core: random and directed trees, predicted in SV.
// Depends on tcf_pkg and the core RTL only.
module tb_tree_centroid_finder_core;

  localparam logic FUNC_EDGE    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;
  localparam int   EDGE_CAP     = tcf_pkg::MaxNodes - 1;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  logic clk_i, rst_ni, start, busy, cfg_we_i, res_valid_o;
  logic [tcf_pkg::NodeW-1:0] cfg_wdata_i;
  tcf_pkg::in_item_t  in_i;
  tcf_pkg::out_item_t res_o;

  tree_centroid_finder_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o), .res_o(res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // predictor state: mirrored node count and the edge store
  int unsigned node_cnt;
  int unsigned edge_x[$];
  int unsigned edge_y[$];
  tcf_pkg::out_item_t centroid_q[$];
  int unsigned fail_cnt, item_cnt, tree_cnt, result_cnt;
  longint      cycle_cnt;
  // sender burst/gap shaping
  int unsigned burst_left;

  // Centroid of what is stored now, with the block's rules for odd input.
  function automatic tcf_pkg::out_item_t centroid_of();
    int unsigned n, reached, sp, v, u, part, best, best_node;
    int unsigned adj[int][$];
    int unsigned up[int], sz[int], order[$], stk[$];
    bit seen[int];
    tcf_pkg::out_item_t r;
    n = node_cnt == 0 ? 1 : (node_cnt > tcf_pkg::MaxNodes ? tcf_pkg::MaxNodes : node_cnt);
    foreach (edge_x[i]) begin
      if (edge_x[i] <= n && edge_y[i] <= n && edge_x[i] != edge_y[i]) begin
        adj[edge_x[i]].push_back(edge_y[i]);
        adj[edge_y[i]].push_back(edge_x[i]);
      end
    end
    // stack walk in the same neighbor order as the block
    stk.push_back(1); seen[1] = 1; up[1] = 0;
    while (stk.size() > 0) begin
      v = stk.pop_back();
      order.push_back(v);
      sz[v] = 1;
      if (adj.exists(v))
        foreach (adj[v][k]) begin
          u = adj[v][k];
          if (!seen.exists(u)) begin
            seen[u] = 1; up[u] = v; stk.push_back(u);
          end
        end
    end
    reached = order.size();
    for (int i = reached - 1; i >= 1; i--) sz[up[order[i]]] += sz[order[i]];
    best = 'h7FF; best_node = 1;
    for (v = 1; v <= n; v++) begin
      if (!seen.exists(v)) part = n - 1;
      else begin
        part = reached - sz[v];
        if (adj.exists(v))
          foreach (adj[v][k]) begin
            u = adj[v][k];
            if (u != 1 && up[u] == v && sz[u] > part) part = sz[u];
          end
      end
      if (v == 1 || part < best) begin best = part; best_node = v; end
    end
    r.centroid_node = best_node[tcf_pkg::NodeW-1:0];
    r.largest_part  = best[tcf_pkg::PartW-1:0];
    return r;
  endfunction

  // Send one item, honoring bursts and gaps; predict on acceptance.
  // start stays high inside a burst; it drops only for a gap or an idle pause.
  task automatic send_item(input logic f, input int unsigned a, input int unsigned b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 4) * ($urandom_range(0, 2) != 0);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_i.func  <= f;
    in_i.end_a <= a[tcf_pkg::NodeW-1:0];
    in_i.end_b <= b[tcf_pkg::NodeW-1:0];
    do @(posedge clk_i); while (busy);
    item_cnt++;
    if (f == FUNC_EDGE) begin
      if (a >= 1 && b >= 1 && a <= tcf_pkg::MaxNodes && b <= tcf_pkg::MaxNodes &&
          edge_x.size() < EDGE_CAP) begin
        edge_x.push_back(a); edge_y.push_back(b);
      end
    end else begin
      centroid_q.push_back(centroid_of());
      edge_x.delete(); edge_y.delete();
      tree_cnt++;
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (centroid_q.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Node count is written only with the block idle.
  task automatic set_nodes(input int unsigned n);
    drain();
    cfg_we_i <= 1'b1; cfg_wdata_i <= n[tcf_pkg::NodeW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    node_cnt = n;
  endtask

  // Random tree on n nodes, edges shuffled and endpoints swapped at random.
  task automatic send_tree(input int unsigned n, input int unsigned shape);
    int unsigned ex[$], ey[$], p, j, t;
    for (int unsigned v = 2; v <= n; v++) begin
      case (shape)
        0: p = v - 1;                              // path
        1: p = 1;                                  // star
        default: p = $urandom_range(1, v - 1);
      endcase
      if ($urandom_range(0, 1)) begin ex.push_back(v); ey.push_back(p); end
      else begin ex.push_back(p); ey.push_back(v); end
    end
    for (int i = ex.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ex[i]; ex[i] = ex[j]; ex[j] = t;
      t = ey[i]; ey[i] = ey[j]; ey[j] = t;
    end
    foreach (ex[i]) send_item(FUNC_EDGE, ex[i], ey[i]);
    send_item(FUNC_COMPUTE, $urandom_range(0, 2047), $urandom_range(0, 2047));
  endtask

  task automatic test_directed();
    set_nodes(1);
    send_item(FUNC_COMPUTE, 0, 0);               // single node
    set_nodes(0);                                // zero treated as one
    send_item(FUNC_COMPUTE, 2047, 2047);
    set_nodes(2);
    send_item(FUNC_EDGE, 1, 2);
    send_item(FUNC_EDGE, 2, 1);                  // duplicate edge
    send_item(FUNC_EDGE, 0, 2);                  // bad endpoint
    send_item(FUNC_EDGE, 2047, 1);               // above the store range
    send_item(FUNC_EDGE, 2, 2);                  // self loop
    send_item(FUNC_EDGE, 1, 1024);               // beyond node count
    send_item(FUNC_COMPUTE, 0, 0);
    set_nodes(5);
    send_item(FUNC_EDGE, 1, 2);                  // disconnected forest
    send_item(FUNC_EDGE, 4, 5);
    send_item(FUNC_COMPUTE, 0, 0);
    send_item(FUNC_EDGE, 1, 2);
    send_item(FUNC_EDGE, 2, 3);
    send_item(FUNC_EDGE, 3, 4);
    send_item(FUNC_EDGE, 4, 5);
    send_item(FUNC_COMPUTE, 0, 0);
  endtask

  // Widest node count setting, with most nodes left unreached.
  task automatic test_extremes();
    set_nodes(2047);                             // clamps to the maximum
    send_tree(30, 2);
    set_nodes(tcf_pkg::MaxNodes);
    send_tree(20, 0);
  endtask

  task automatic test_random();
    int unsigned k;
    k = 0;
    while (k < 380) begin
      set_nodes($urandom_range(1, 24));
      for (int r = 0; r < 4; r++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: arbitrary endpoints, then a compute
          repeat ($urandom_range(1, 6))
            send_item(FUNC_EDGE, $urandom_range(0, 2047), $urandom_range(0, 2047));
          send_item(FUNC_COMPUTE, 0, 0);
        end else send_tree(node_cnt, $urandom_range(0, 5));
        k += node_cnt;
      end
    end
    // once, pause until every result is in before going on
    drain();
    send_tree(node_cnt, 2);
  endtask

  // Result checker: each strobe pops the oldest prediction, or is flagged if none is left.
  always @(posedge clk_i) begin
    tcf_pkg::out_item_t want;
    if (rst_ni && res_valid_o) begin
      result_cnt++;
      if (centroid_q.size() == 0) begin
        $error("unexpected result node %0d part %0d", res_o.centroid_node, res_o.largest_part);
        fail_cnt++;
      end else begin
        want = centroid_q.pop_front();
        if (res_o.centroid_node !== want.centroid_node) begin
          $error("centroid_node expected %0d actual %0d",
                 want.centroid_node, res_o.centroid_node);
          fail_cnt++;
        end
        if (res_o.largest_part !== want.largest_part) begin
          $error("largest_part expected %0d actual %0d",
                 want.largest_part, res_o.largest_part);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    fail_cnt = 0; item_cnt = 0; tree_cnt = 0; result_cnt = 0; cycle_cnt = 0;
    burst_left = 0; node_cnt = 1;
    rst_ni = 1'b0; start = 1'b0; in_i = '0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_extremes();
    test_random();
    drain();
    if (centroid_q.size() != 0) fail_cnt++;
    $display("sent %0d items in %0d trees; %0d centroids checked", item_cnt, tree_cnt,
             result_cnt);
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: tree_centroid_finder_core.f
rtl/tcf_pkg.sv
rtl/tcf_ctrl.sv
rtl/tcf_datapath.sv
rtl/tree_centroid_finder_core.sv
tb/tb_tree_centroid_finder_core.sv
